>>> hdl/assert_macros.svh
// Assertion macros shared by the pricer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ABP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ABP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ABP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/abp_pkg.sv
// Types, constants and helper functions of the binomial pricer.
`timescale 1ns / 1ps
package abp_pkg;
    localparam int MAX_STEPS = 64;
    localparam int SP_DEPTH  = 2 * MAX_STEPS + 1;
    localparam int SP_AW     = $clog2(SP_DEPTH);
    localparam int VAL_DEPTH = MAX_STEPS + 1;
    localparam int VAL_AW    = $clog2(VAL_DEPTH);
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int DIV_CNT_W = 6;
    localparam int REM_W     = 38;
    localparam int DSR_W     = 37;

    localparam logic [1:0] CFG_NUM_STEPS   = 2'd0;
    localparam logic [1:0] CFG_OPTION_TYPE = 2'd1;
    localparam logic [1:0] CFG_UP_FACTOR   = 2'd2;
    localparam logic [1:0] CFG_RATE        = 2'd3;

    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;
    localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

    localparam logic [DIV_CNT_W-1:0] DN_DIV_STEPS   = DIV_CNT_W'(57);
    localparam logic [DIV_CNT_W-1:0] FRAC_DIV_STEPS = DIV_CNT_W'(32);

    typedef enum logic [4:0] {
        S_IDLE, S_DN_ST, S_DN_WT, S_P_ST, S_P_WT, S_Q_ST, S_Q_WT,
        S_SP_INIT, S_SP_CHK, S_SP_MUL, S_SP_WR,
        S_RD_A, S_LD_A, S_RD_B, S_LD_B, S_MUL_P, S_MUL_Q,
        S_DIV_ST, S_DIV_WT, S_WR, S_DONE
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [REM_W-1:0]     rem;
        logic [63:0]          dvd;
        logic [DSR_W-1:0]     dsr;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic        accum;
        logic [31:0] a;
        logic [31:0] b;
    } t_mac_req;

    function automatic logic [31:0] intrinsic(input logic [31:0] s, input logic [31:0] k,
                                              input logic put);
        logic [31:0] res;
        if (put) begin
            res = (k > s) ? k - s : 32'd0;
        end else begin
            res = (s > k) ? s - k : 32'd0;
        end
        return res;
    endfunction
endpackage

>>> hdl/abp_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module abp_div import abp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [REM_W-1:0]     r_rem;
    logic [63:0]          r_dvd;
    logic [DSR_W-1:0]     r_dsr;
    logic [31:0]          r_quo;
    logic [REM_W-1:0]     w_sh;
    logic                 w_ge;

    assign w_sh = {r_rem[REM_W-2:0], r_dvd[63]};
    assign w_ge = w_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_dvd <= i_req.dvd;
            r_dsr <= i_req.dsr;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sh - {1'b0, r_dsr} : w_sh;
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
endmodule

>>> hdl/abp_mac.sv
// Shared 32x32 multiply-accumulate unit with registered result.
`timescale 1ns / 1ps
module abp_mac import abp_pkg::*; (
    input  logic        i_clk,
    input  t_mac_req    i_req,
    output logic [64:0] o_acc
);
    logic [64:0] r_acc;
    logic [63:0] w_prod;

    assign w_prod = {32'd0, i_req.a} * {32'd0, i_req.b};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= (i_req.accum ? r_acc : 65'd0) + {1'b0, w_prod};
        end
    end

    assign o_acc = r_acc;
endmodule

>>> hdl/american_option_binomial_pricer.sv
// American option pricer on a CRR binomial tree; top level with sequencer and node memories.
// One request (spot, strike) yields one price and a bad_params flag. The block handles one
// request at a time: setup runs a 57-step division for the down factor and two 32-step
// divisions for the weights, then the leaf spot table is built, and each of the N*(N+1)/2
// tree nodes spends almost all of its time in the shared bit-per-cycle divider that
// applies the discount.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module american_option_binomial_pricer import abp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_spot_price,
    input  logic [31:0] i_strike_price,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_option_price,
    output logic        o_bad_params
);
    t_state r_state, n_state;

    logic [6:0]  r_num_steps;
    logic        r_opt;
    logic [31:0] r_up, r_rate;

    logic [31:0] r_spot, r_strike, r_dn, r_p, r_q, r_cur, r_a, r_b, r_res, r_price;
    logic        r_bad, r_dir_dn;
    logic [STEP_W-1:0] r_n, r_k, r_lvl, r_i;

    logic [31:0] m_spot [SP_DEPTH];
    logic [31:0] m_val  [VAL_DEPTH];
    logic [31:0] r_spot_q, r_val_q;

    logic              sp_we, val_we;
    logic [SP_AW-1:0]  sp_waddr, sp_raddr;
    logic [VAL_AW-1:0] val_waddr, val_raddr;
    logic [31:0]       sp_wdata;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_mac_req    mac_req;
    logic [64:0] mac_acc;

    logic [STEP_W-1:0] w_n_clamp;
    logic        w_up_big, w_first, w_sat_node;
    logic [35:0] w_u, w_d, w_r, w_denom, w_pn, w_qn;
    logic [35:0] w_sp_prod;
    logic [31:0] w_sp_next, w_node, w_mem_val;
    logic [SP_AW-1:0] w_k1;

    abp_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    abp_mac u_mac (.i_clk(i_clk), .i_req(mac_req), .o_acc(mac_acc));

    assign w_n_clamp = (32'(r_num_steps) > MAX_STEPS) ? STEP_W'(MAX_STEPS)
                                                       : STEP_W'(r_num_steps);
    assign w_up_big  = r_up > ONE_Q28;
    assign w_u       = {r_up, 4'd0};
    assign w_d       = {r_dn, 4'd0};
    assign w_r       = {3'd0, 1'b1, r_rate};
    assign w_denom   = w_u - w_d;
    assign w_pn      = w_r - w_d;
    assign w_qn      = (w_u > w_r) ? w_u - w_r : 36'd0;
    assign w_sp_prod = mac_acc[63:28];
    assign w_sp_next = (!r_dir_dn && (w_sp_prod[35:32] != 4'd0)) ? MAX32 : w_sp_prod[31:0];
    assign w_k1      = SP_AW'(r_k) + SP_AW'(1);
    assign w_first   = (r_lvl == r_n);
    assign w_mem_val = w_first ? 32'd0 : r_val_q;
    assign w_node    = (w_mem_val > intrinsic(r_spot_q, r_strike, r_opt))
                     ? w_mem_val : intrinsic(r_spot_q, r_strike, r_opt);
    assign w_sat_node = mac_acc[64:32] >= {1'b1, r_rate};

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_steps <= 7'd3;
            r_opt       <= 1'b0;
            r_up        <= 32'd335544320;
            r_rate      <= 32'd107374182;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_STEPS:   r_num_steps <= i_cfg_wdata[6:0];
                CFG_OPTION_TYPE: r_opt       <= i_cfg_wdata[0];
                CFG_UP_FACTOR:   r_up        <= i_cfg_wdata;
                CFG_RATE:        r_rate      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = w_up_big ? S_DN_ST : S_SP_INIT;
            S_DN_ST:   n_state = S_DN_WT;
            S_DN_WT:   if (div_rsp.done) n_state = S_P_ST;
            S_P_ST:    n_state = (w_pn < w_denom) ? S_P_WT : S_Q_ST;
            S_P_WT:    if (div_rsp.done) n_state = S_Q_ST;
            S_Q_ST:    n_state = (w_qn < w_denom) ? S_Q_WT : S_SP_INIT;
            S_Q_WT:    if (div_rsp.done) n_state = S_SP_INIT;
            S_SP_INIT: n_state = S_SP_CHK;
            S_SP_CHK:  begin
                if (r_k != r_n) begin
                    n_state = S_SP_MUL;
                end else if (r_dir_dn) begin
                    n_state = S_RD_A;
                end
            end
            S_SP_MUL:  n_state = S_SP_WR;
            S_SP_WR:   n_state = S_SP_CHK;
            S_RD_A:    n_state = S_LD_A;
            S_LD_A:    n_state = (r_lvl == '0) ? S_DONE : S_RD_B;
            S_RD_B:    n_state = S_LD_B;
            S_LD_B:    n_state = S_MUL_P;
            S_MUL_P:   n_state = S_MUL_Q;
            S_MUL_Q:   n_state = S_DIV_ST;
            S_DIV_ST:  n_state = w_sat_node ? S_WR : S_DIV_WT;
            S_DIV_WT:  if (div_rsp.done) n_state = S_WR;
            S_WR:      n_state = (r_i + STEP_W'(1) == r_lvl) ? S_RD_A : S_RD_B;
            S_DONE:    if (i_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        div_req   = '0;
        mac_req   = '0;
        sp_we     = 1'b0;
        sp_waddr  = SP_AW'(MAX_STEPS);
        sp_wdata  = r_spot;
        sp_raddr  = SP_AW'(MAX_STEPS) + SP_AW'(r_lvl);
        val_we    = 1'b0;
        val_waddr = VAL_AW'(r_i);
        val_raddr = '0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_DN_ST: begin
                div_req.start = 1'b1;
                div_req.steps = DN_DIV_STEPS;
                div_req.rem   = '0;
                div_req.dvd   = {1'b1, 63'd0};
                div_req.dsr   = {5'd0, r_up};
            end
            S_P_ST: begin
                div_req.start = w_pn < w_denom;
                div_req.steps = FRAC_DIV_STEPS;
                div_req.rem   = {2'd0, w_pn};
                div_req.dvd   = '0;
                div_req.dsr   = {1'b0, w_denom};
            end
            S_Q_ST: begin
                div_req.start = w_qn < w_denom;
                div_req.steps = FRAC_DIV_STEPS;
                div_req.rem   = {2'd0, w_qn};
                div_req.dvd   = '0;
                div_req.dsr   = {1'b0, w_denom};
            end
            S_SP_INIT: sp_we = 1'b1;
            S_SP_MUL: begin
                mac_req.start = 1'b1;
                mac_req.a     = r_cur;
                mac_req.b     = r_dir_dn ? r_dn : r_up;
            end
            S_SP_WR: begin
                sp_we    = 1'b1;
                sp_wdata = w_sp_next;
                sp_waddr = r_dir_dn ? SP_AW'(MAX_STEPS) - w_k1 : SP_AW'(MAX_STEPS) + w_k1;
            end
            S_RD_B: begin
                val_raddr = VAL_AW'(r_i) + VAL_AW'(1);
                sp_raddr  = SP_AW'(MAX_STEPS) + SP_AW'(r_lvl) - SP_AW'({r_i, 1'b0})
                          - SP_AW'(2);
            end
            S_MUL_P: begin
                mac_req.start = 1'b1;
                mac_req.a     = r_a;
                mac_req.b     = r_p;
            end
            S_MUL_Q: begin
                mac_req.start = 1'b1;
                mac_req.accum = 1'b1;
                mac_req.a     = r_b;
                mac_req.b     = r_q;
            end
            S_DIV_ST: begin
                div_req.start = !w_sat_node;
                div_req.steps = FRAC_DIV_STEPS;
                div_req.rem   = {5'd0, mac_acc[64:32]};
                div_req.dvd   = {mac_acc[31:0], 32'd0};
                div_req.dsr   = {4'd0, 1'b1, r_rate};
            end
            S_WR: begin
                val_we = 1'b1;
            end
            S_DONE: o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_spot   <= i_spot_price;
                r_strike <= i_strike_price;
                r_n      <= w_n_clamp;
                r_dn     <= ONE_Q28;
                r_p      <= MAX32;
                r_q      <= 32'd0;
                r_bad    <= 1'b1;
            end
            S_DN_WT: if (div_rsp.done) r_dn <= div_rsp.quot;
            S_P_ST: begin
                r_bad <= !(w_r < w_u);
                r_p   <= MAX32;
            end
            S_P_WT: if (div_rsp.done) r_p <= div_rsp.quot;
            S_Q_ST: r_q <= MAX32;
            S_Q_WT: if (div_rsp.done) r_q <= div_rsp.quot;
            S_SP_INIT: begin
                r_cur    <= r_spot;
                r_k      <= '0;
                r_dir_dn <= 1'b0;
            end
            S_SP_CHK: begin
                if (r_k == r_n) begin
                    r_dir_dn <= 1'b1;
                    r_k      <= '0;
                    r_cur    <= r_spot;
                    r_lvl    <= r_n;
                end
            end
            S_SP_WR: begin
                r_cur <= w_sp_next;
                r_k   <= r_k + STEP_W'(1);
            end
            S_LD_A: begin
                r_a     <= w_node;
                r_price <= w_node;
                r_i     <= '0;
            end
            S_LD_B: r_b <= w_node;
            S_DIV_ST: r_res <= MAX32;
            S_DIV_WT: if (div_rsp.done) r_res <= div_rsp.quot;
            S_WR: begin
                r_a <= r_b;
                if (r_i + STEP_W'(1) == r_lvl) begin
                    r_lvl <= r_lvl - STEP_W'(1);
                end else begin
                    r_i <= r_i + STEP_W'(1);
                end
            end
            default: ;
        endcase
    end

    // node memories
    always_ff @(posedge i_clk) begin
        if (sp_we) begin
            m_spot[sp_waddr] <= sp_wdata;
        end
        r_spot_q <= m_spot[sp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            m_val[val_waddr] <= r_res;
        end
        r_val_q <= m_val[val_raddr];
    end

    assign o_option_price = r_price;
    assign o_bad_params   = r_bad;

    `ABP_ASSERT(a_no_req_while_result, i_clk, i_rst_n, o_valid |-> !o_ready, "request taken while result pending")
    `ABP_ASSERT(a_node_in_level, i_clk, i_rst_n, (r_state == S_WR) |-> (r_i < r_lvl), "node index beyond level")
    `ABP_ASSERT(a_level_bound, i_clk, i_rst_n, (r_state == S_RD_B) |-> (r_lvl <= r_n), "level above step count")
    `ABP_ASSERT(a_div_idle_start, i_clk, i_rst_n, div_req.start |=> !div_rsp.done, "divider done right after start")
endmodule

>>> sim/american_option_binomial_pricer_tb.sv
// Testbench for the binomial option pricer: random and directed requests checked by a scoreboard.
`timescale 1ns / 1ps
module american_option_binomial_pricer_tb import abp_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int NUM_ITEMS      = 270;

    class price_scoreboard;
        logic [6:0]  n_steps;
        logic        is_put;
        logic [31:0] up_q28;
        logic [31:0] rate_q32;
        logic [31:0] exp_price[$];
        logic        exp_bad[$];
        int          errors;

        function new();
            n_steps  = 7'd3;
            is_put   = 1'b0;
            up_q28   = 32'd335544320;
            rate_q32 = 32'd107374182;
            errors   = 0;
        endfunction

        function logic [31:0] payoff(logic [31:0] s, logic [31:0] k);
            if (is_put) return (k > s) ? k - s : 32'd0;
            return (s > k) ? s - k : 32'd0;
        endfunction

        function logic [31:0] move_spot(logic [31:0] s, int e, logic [31:0] dn);
            logic [63:0] v;
            v = {32'd0, s};
            for (int j = 0; j < (e < 0 ? -e : e); j++) begin
                v = (v * (e > 0 ? {32'd0, up_q28} : {32'd0, dn})) >> 28;
                if (v > {32'd0, MAX32}) v = {32'd0, MAX32};
            end
            return v[31:0];
        endfunction

        function logic [31:0] frac_quot(logic [63:0] num, logic [63:0] den);
            logic [64:0] rem;
            logic [31:0] quo;
            rem = {1'b0, num};
            quo = '0;
            for (int j = 0; j < 32; j++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= {1'b0, den}) begin
                    rem = rem - {1'b0, den};
                    quo[0] = 1'b1;
                end
            end
            return quo;
        endfunction

        function void note_request(logic [31:0] spot, logic [31:0] strike);
            logic [31:0] vals[0:MAX_STEPS];
            logic [31:0] spots[0:MAX_STEPS];
            logic [31:0] dn, pw, qw, a, b;
            logic [63:0] onepr, up32, dn32, den, pn, qn;
            logic [65:0] acc, v;
            logic        bad;
            int          n;
            n = (n_steps > MAX_STEPS) ? MAX_STEPS : int'(n_steps);
            onepr = 64'h1_0000_0000 + {32'd0, rate_q32};
            if (up_q28 > ONE_Q28) begin
                dn   = 32'((64'd1 << 56) / {32'd0, up_q28});
                up32 = {32'd0, up_q28} << 4;
                dn32 = {32'd0, dn} << 4;
                den  = up32 - dn32;
                pn   = onepr - dn32;
                qn   = (up32 > onepr) ? up32 - onepr : 64'd0;
                bad  = !(dn32 < onepr && onepr < up32);
                pw   = (pn < den) ? frac_quot(pn, den) : MAX32;
                qw   = (qn < den) ? frac_quot(qn, den) : MAX32;
            end else begin
                bad = 1'b1;
                dn  = ONE_Q28;
                pw  = MAX32;
                qw  = 32'd0;
            end
            for (int i = 0; i <= n; i++) begin
                spots[i] = move_spot(spot, n - 2 * i, dn);
                vals[i]  = payoff(spots[i], strike);
            end
            for (int lvl = n; lvl >= 1; lvl--) begin
                for (int i = 0; i < lvl; i++) begin
                    a = payoff(spots[i], strike);
                    b = payoff(spots[i+1], strike);
                    if (vals[i] > a) a = vals[i];
                    if (vals[i+1] > b) b = vals[i+1];
                    acc = 66'(a) * 66'(pw) + 66'(b) * 66'(qw);
                    v = acc / 66'(onepr);
                    vals[i] = (v > 66'(MAX32)) ? MAX32 : v[31:0];
                end
                for (int i = 0; i < lvl; i++) spots[i] = move_spot(spot, lvl - 1 - 2 * i, dn);
            end
            a = payoff(spots[0], strike);
            exp_price.insert(exp_price.size(), vals[0] > a ? vals[0] : a);
            exp_bad.insert(exp_bad.size(), bad);
        endfunction

        function void check_result(logic [31:0] price, logic bad);
            logic [31:0] ep;
            logic        eb;
            if (exp_price.size() == 0) begin
                $display("%0t: unexpected result price=%h bad=%b", $time, price, bad);
                errors++;
                return;
            end
            ep = exp_price.pop_front();
            eb = exp_bad.pop_front();
            if (price !== ep) begin
                $display("%0t: option_price expected %h actual %h", $time, ep, price);
                errors++;
            end
            if (bad !== eb) begin
                $display("%0t: bad_params expected %b actual %b", $time, eb, bad);
                errors++;
            end
        endfunction

        function int pending();
            return exp_price.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_spot_price;
    logic [31:0] i_strike_price;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_option_price;
    logic        o_bad_params;

    price_scoreboard sb = new();
    int results_seen = 0;
    int idle_cycles  = 0;
    int sent         = 0;

    american_option_binomial_pricer u_top (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_option_price, o_bad_params);
            results_seen++;
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall pattern, one long hold-off
    initial begin
        int mode;
        int held;
        i_ready = 1'b0;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 40) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
            end
            mode = $urandom_range(0, 9);
            if (mode < 3) i_ready <= 1'b1;
            else if (mode < 5) i_ready <= 1'b0;
            else i_ready <= $urandom_range(0, 1);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_NUM_STEPS:   sb.n_steps  = data[6:0];
            CFG_OPTION_TYPE: sb.is_put   = data[0];
            CFG_UP_FACTOR:   sb.up_q28   = data;
            default:         sb.rate_q32 = data;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // offer one request, return at the falling edge after it is taken
    task automatic send_request(logic [31:0] spot, logic [31:0] strike);
        i_valid        <= 1'b1;
        i_spot_price   <= spot;
        i_strike_price <= strike;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(spot, strike);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic random_request();
        logic [31:0] s, k;
        if ($urandom_range(0, 3) == 0) begin
            s = $urandom();
            k = $urandom();
        end else begin
            s = $urandom_range(0, 200 << 16);
            k = s + $urandom_range(0, 40 << 16) - (20 << 16);
        end
        send_request(s, k);
    endtask

    initial begin
        int burst;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_NUM_STEPS;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_spot_price   = '0;
        i_strike_price = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: operand extremes with both option kinds
        for (int t = 0; t < 2; t++) begin
            write_reg(CFG_OPTION_TYPE, 32'(t));
            send_request(32'd0, 32'd0);
            send_request(MAX32, 32'd0);
            send_request(32'd0, MAX32);
            send_request(MAX32, MAX32);
            send_request(32'd100 << 16, 32'd90 << 16);
            drain();
        end
        // rate too high for the up move
        write_reg(CFG_RATE, 32'h8000_0000);
        send_request(32'd100 << 16, 32'd100 << 16);
        drain();
        write_reg(CFG_RATE, 32'd0);
        // up factor not above one, then very large and just above one
        write_reg(CFG_UP_FACTOR, ONE_Q28);
        send_request(32'd50 << 16, 32'd60 << 16);
        drain();
        write_reg(CFG_UP_FACTOR, 32'd0);
        send_request(32'd50 << 16, 32'd40 << 16);
        drain();
        write_reg(CFG_UP_FACTOR, MAX32);
        send_request(32'd50 << 16, 32'd40 << 16);
        drain();
        write_reg(CFG_UP_FACTOR, 32'h1000_0001);
        write_reg(CFG_RATE, 32'd1000);
        send_request(32'd80 << 16, 32'd80 << 16);
        drain();
        // step count extremes
        write_reg(CFG_UP_FACTOR, 32'h1200_0000);
        write_reg(CFG_NUM_STEPS, 32'd0);
        send_request(32'd70 << 16, 32'd80 << 16);
        drain();
        write_reg(CFG_NUM_STEPS, 32'd1);
        send_request(32'd70 << 16, 32'd80 << 16);
        drain();
        write_reg(CFG_NUM_STEPS, 32'd64);
        send_request(32'd100 << 16, 32'd105 << 16);
        drain();
        write_reg(CFG_NUM_STEPS, 32'd127);
        write_reg(CFG_OPTION_TYPE, 32'd0);
        send_request(32'd100 << 16, 32'd95 << 16);
        drain();

        // random phases
        while (sent < NUM_ITEMS) begin
            write_reg(CFG_NUM_STEPS, ($urandom_range(0, 9) == 0) ?
                      $urandom_range(0, 12) : $urandom_range(1, 6));
            write_reg(CFG_OPTION_TYPE, $urandom_range(0, 1));
            write_reg(CFG_UP_FACTOR, ($urandom_range(0, 4) == 0) ? $urandom() :
                      $urandom_range(32'h1000_0001, 32'h1800_0000));
            write_reg(CFG_RATE, ($urandom_range(0, 4) == 0) ?
                      $urandom_range(0, 32'h8000_0000) : $urandom_range(0, 32'h0400_0000));
            for (int j = $urandom_range(10, 25); j > 0; ) begin
                burst = $urandom_range(1, 8);
                for (; burst > 0 && j > 0; burst--, j--) random_request();
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(negedge i_clk);
                end
            end
            drain();
        end

        repeat (100) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
